[src/exp_golomb_bit_reader_defines.svh]
// Assertion macros shared by the bit reader modules
`ifndef EXP_GOLOMB_BIT_READER_DEFINES_SVH
`define EXP_GOLOMB_BIT_READER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, clocked on aclk, quiet during reset
`define EGBR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bit reader assertion failed");

// next-cycle implication
`define EGBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bit reader assertion failed");

`else

`define EGBR_ASSERT_IMP(lbl, ante, cons)
`define EGBR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/egbr_pkg.sv]
// Types, constants and helpers for the Exp-Golomb bit reader
package egbr_pkg;

    localparam int EGBR_STORE_BITS = 128;
    localparam int BYTE_BITS       = 8;
    localparam int UE_MAX_ZEROS    = 31;
    localparam int WINDOW_BITS     = 32;
    localparam int READ_MAX        = 64;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_READ    = 3'd1,
        CMD_READ_UE = 3'd2,
        CMD_READ_SE = 3'd3,
        CMD_SKIP    = 3'd4,
        CMD_RESTART = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_BADCODE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_PREFIX,
        FSM_SUFFIX,
        FSM_OUT
    } fsm_state_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_EXEC,
        DP_PREFIX,
        DP_SUFFIX,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pfx_more;
        logic pfx_to_suffix;
        logic out_free;
    } dp_stat_t;

    // leading zeros of a nonzero 32-bit word, binary search
    function automatic logic [4:0] lzc32(input logic [31:0] w);
        logic [31:0] x;
        logic [4:0]  n;
        begin
            x = w;
            n = '0;
            if (x[31:16] == 16'd0) begin
                n[4] = 1'b1;
                x = x << 16;
            end
            if (x[31:24] == 8'd0) begin
                n[3] = 1'b1;
                x = x << 8;
            end
            if (x[31:28] == 4'd0) begin
                n[2] = 1'b1;
                x = x << 4;
            end
            if (x[31:30] == 2'd0) begin
                n[1] = 1'b1;
                x = x << 2;
            end
            if (x[31] == 1'b0) begin
                n[0] = 1'b1;
            end
            return n;
        end
    endfunction

endpackage

[src/egbr_ctrl.sv]
// Sequencing state machine for the bit reader
`include "exp_golomb_bit_reader_defines.svh"

module egbr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  egbr_pkg::cmd_t     in_cmd,
    output logic               s_ready,
    input  egbr_pkg::dp_stat_t stat,
    output egbr_pkg::dp_cmd_t  cmd
);
    import egbr_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = DP_NONE;
        case (state_reg)
            FSM_IDLE: begin
                s_ready = aresetn;
                if (aresetn && s_valid) begin
                    cmd.capture = 1'b1;
                    if (in_cmd == CMD_READ_UE || in_cmd == CMD_READ_SE) begin
                        state_next = FSM_PREFIX;
                    end else begin
                        state_next = FSM_EXEC;
                    end
                end
            end
            FSM_EXEC: begin
                cmd.op     = DP_EXEC;
                state_next = FSM_OUT;
            end
            FSM_PREFIX: begin
                cmd.op = DP_PREFIX;
                if (stat.pfx_more) begin
                    state_next = FSM_PREFIX;
                end else if (stat.pfx_to_suffix) begin
                    state_next = FSM_SUFFIX;
                end else begin
                    state_next = FSM_OUT;
                end
            end
            FSM_SUFFIX: begin
                cmd.op     = DP_SUFFIX;
                state_next = FSM_OUT;
            end
            FSM_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = DP_OUT;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    `EGBR_ASSERT_NEXT(a_accept_leaves_idle, state_reg == FSM_IDLE && s_valid, state_reg == FSM_EXEC || state_reg == FSM_PREFIX)
    `EGBR_ASSERT_NEXT(a_result_waits, state_reg == FSM_OUT && !stat.out_free, state_reg == FSM_OUT)
    `EGBR_ASSERT_NEXT(a_suffix_single, state_reg == FSM_SUFFIX, state_reg == FSM_OUT)

endmodule

[src/egbr_datapath.sv]
// Bit store, shifters, prefix search and result registers
`include "exp_golomb_bit_reader_defines.svh"

module egbr_datapath #(
    parameter int STORE_BITS = egbr_pkg::EGBR_STORE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        s_tdata,
    input  egbr_pkg::cmd_t     in_cmd,
    input  egbr_pkg::dp_cmd_t  cmd,
    output egbr_pkg::dp_stat_t stat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [111:0]       m_tdata
);
    import egbr_pkg::*;

    localparam int HW = $clog2(STORE_BITS + 1);

    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [HW-1:0]         held_reg, held_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [7:0]            byte_reg, byte_next;
    logic [6:0]            count_reg, count_next;
    logic                  long_reg, long_next;
    logic [4:0]            z_reg, z_next;
    logic [63:0]           vu_reg, vu_next;
    logic [31:0]           vs_reg, vs_next;
    status_t               st_reg, st_next;
    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           m_vu_reg, m_vu_next;
    logic [31:0]           m_vs_reg, m_vs_next;
    status_t               m_st_reg, m_st_next;
    logic [7:0]            m_held_reg, m_held_next;

    logic [63:0] top64;
    logic [31:0] window;
    logic        window_zero;
    logic [4:0]  lz;
    logic [5:0]  pfx_len;
    logic [6:0]  rd_len;
    logic [31:0] suffix;
    logic [31:0] code_k;

    assign top64       = store_reg[STORE_BITS-1 -: READ_MAX];
    assign window      = store_reg[STORE_BITS-1 -: WINDOW_BITS];
    assign window_zero = (window == '0);
    assign lz          = lzc32(window);
    assign pfx_len     = {1'b0, lz} + 6'd1;
    assign rd_len      = (count_reg > 7'(READ_MAX)) ? 7'(READ_MAX) : count_reg;
    assign suffix      = 32'(top64 >> (7'(READ_MAX) - {2'b00, z_reg}));
    assign code_k      = ((32'd1 << z_reg) - 32'd1) + suffix;

    assign stat.pfx_more      = window_zero && (held_reg > HW'(WINDOW_BITS));
    assign stat.pfx_to_suffix = !window_zero && !long_reg;
    assign stat.out_free      = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, m_held_reg, m_st_reg, m_vs_reg, m_vu_reg};

    always_comb begin
        store_next   = store_reg;
        held_next    = held_reg;
        cmd_next     = cmd_reg;
        byte_next    = byte_reg;
        count_next   = count_reg;
        long_next    = long_reg;
        z_next       = z_reg;
        vu_next      = vu_reg;
        vs_next      = vs_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg;
        m_vu_next    = m_vu_reg;
        m_vs_next    = m_vs_reg;
        m_st_next    = m_st_reg;
        m_held_next  = m_held_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.capture) begin
            cmd_next   = in_cmd;
            byte_next  = s_tdata[7:0];
            count_next = s_tdata[14:8];
            long_next  = 1'b0;
            vu_next    = '0;
            vs_next    = '0;
            st_next    = ST_OK;
        end

        case (cmd.op)
            DP_EXEC: begin
                case (cmd_reg)
                    CMD_LOAD: begin
                        if ({1'b0, held_reg} + (HW+1)'(BYTE_BITS) > (HW+1)'(STORE_BITS)) begin
                            st_next = ST_OVERFLOW;
                        end else begin
                            store_next = store_reg |
                                ({byte_reg, (STORE_BITS-BYTE_BITS)'(0)} >> held_reg);
                            held_next  = held_reg + HW'(BYTE_BITS);
                        end
                    end
                    CMD_READ: begin
                        if (held_reg < HW'(rd_len)) begin
                            store_next = '0;
                            held_next  = '0;
                            st_next    = ST_SHORT;
                        end else begin
                            vu_next    = top64 >> (7'(READ_MAX) - rd_len);
                            store_next = store_reg << rd_len;
                            held_next  = held_reg - HW'(rd_len);
                        end
                    end
                    CMD_SKIP: begin
                        if (held_reg < HW'(count_reg)) begin
                            store_next = '0;
                            held_next  = '0;
                            st_next    = ST_SHORT;
                        end else begin
                            store_next = store_reg << count_reg;
                            held_next  = held_reg - HW'(count_reg);
                        end
                    end
                    CMD_RESTART: begin
                        store_next = '0;
                        held_next  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            DP_PREFIX: begin
                if (window_zero) begin
                    if (held_reg <= HW'(WINDOW_BITS)) begin
                        // zero run reaches the end of the store
                        store_next = '0;
                        held_next  = '0;
                        st_next    = ST_SHORT;
                    end else begin
                        store_next = store_reg << WINDOW_BITS;
                        held_next  = held_reg - HW'(WINDOW_BITS);
                        long_next  = 1'b1;
                    end
                end else begin
                    store_next = store_reg << pfx_len;
                    held_next  = held_reg - HW'(pfx_len);
                    if (long_reg) begin
                        st_next = ST_BADCODE;
                    end else begin
                        z_next = lz;
                    end
                end
            end
            DP_SUFFIX: begin
                if (held_reg < HW'(z_reg)) begin
                    store_next = '0;
                    held_next  = '0;
                    st_next    = ST_SHORT;
                end else begin
                    store_next = store_reg << z_reg;
                    held_next  = held_reg - HW'(z_reg);
                    if (z_reg == 5'(UE_MAX_ZEROS) && suffix != '0) begin
                        st_next = ST_BADCODE;
                    end else if (cmd_reg == CMD_READ_UE) begin
                        vu_next = 64'(code_k);
                    end else if (code_k[0]) begin
                        vs_next = {1'b0, code_k[31:1]} + 32'd1;
                    end else begin
                        vs_next = 32'd0 - {1'b0, code_k[31:1]};
                    end
                end
            end
            DP_OUT: begin
                m_valid_next = 1'b1;
                m_vu_next    = vu_reg;
                m_vs_next    = vs_reg;
                m_st_next    = st_reg;
                m_held_next  = 8'(held_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            store_reg   <= store_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        count_reg  <= count_next;
        long_reg   <= long_next;
        z_reg      <= z_next;
        vu_reg     <= vu_next;
        vs_reg     <= vs_next;
        st_reg     <= st_next;
        m_vu_reg   <= m_vu_next;
        m_vs_reg   <= m_vs_next;
        m_st_reg   <= m_st_next;
        m_held_reg <= m_held_next;
    end

    `EGBR_ASSERT_IMP(a_held_bound, 1'b1, {1'b0, held_reg} <= (HW+1)'(STORE_BITS))
    `EGBR_ASSERT_IMP(a_tail_clear, 1'b1, (store_reg << held_reg) == '0)
    `EGBR_ASSERT_NEXT(a_result_loaded, cmd.op == DP_OUT, m_valid_reg)

endmodule

[src/exp_golomb_bit_reader.sv]
// Top level of the Exp-Golomb bitstream reader
//
//   channel | dir | tdata (low bit up)                               | tuser
//   s_      | in  | data_byte[7:0], bit_count[14:8], zero pad         | cmd[2:0]
//   m_      | out | value_unsigned, value_signed, status, bits_held   | -
//
// One transaction at a time: load, read, skip and restart pass an execute state
// and then the output state; ue/se pass a prefix state once per 32-bit window
// searched, a suffix state if the prefix ends in the first window, then output.
// Synchronous active-low reset empties the store and holds s_tready low.
// A result waits in the output register; the next transaction is accepted
// meanwhile but holds in its final cycle until that register frees.
module exp_golomb_bit_reader #(
    parameter int STORE_BITS = egbr_pkg::EGBR_STORE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // data_byte[7:0], bit_count[14:8]
    input  logic [2:0]   s_tuser,   // cmd[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // value_unsigned[63:0], value_signed[95:64],
                                    // status[97:96], bits_held[105:98]
);
    import egbr_pkg::*;

    cmd_t     in_cmd;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign in_cmd = cmd_t'(s_tuser);

    egbr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .in_cmd  (in_cmd),
        .s_ready (s_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    egbr_datapath #(
        .STORE_BITS (STORE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .in_cmd   (in_cmd),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
